### hw/rtl/pact_pkg.sv
// pact_pkg: shared types and fixed widths for the port access counter table
// used by pact_rem and port_access_counter_table_top; no dependencies
package pact_pkg;

    localparam int KEY_W   = 16;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 5;
    localparam int BOUT_W  = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd11;
    localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] COUNT_ONE = 32'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CMP,
        ST_UPD,
        ST_DONE
    } t_state;

endpackage

### hw/rtl/port_access_counter_table_top.sv
// port_access_counter_table_top: per-port access counter in a bucketed hash table
// depends on pact_pkg and pact_rem
//
// Usage
//   input channel : i_in_valid / o_in_ready, word is i_port_number
//   output channel: o_out_valid / i_out_ready, word is bucket index, hit flag,
//                   saturating count and drop flag; one result word per input word
//   config        : i_cfg_we writes the bucket count (hash modulus) at once
// Flow
//   an accepted word passes through the serial remainder unit, then a read
//   state and a compare state per way on the bucket through the single port
//   of the key/count memory, an update state and the output register;
//   the next word is accepted the cycle after the result reaches the output
//   register, so a new word is not taken while one is still in flight
// Reset
//   clears all valid bits (empty table) and loads a bucket count of 11;
//   the key and count memories are not cleared
// Stall
//   a held result stays in the output register; the next word is processed
//   and then waits after its update until the output register frees
module port_access_counter_table_top #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pact_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pact_pkg::KEY_W-1:0]    i_port_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pact_pkg::BOUT_W-1:0]   o_bucket_index,
    output logic                          o_was_present,
    output logic [pact_pkg::CNT_W-1:0]    o_access_count,
    output logic                          o_dropped
);
    import pact_pkg::*;

    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;

    t_state              r_state;
    t_state              n_state;

    logic [CFG_W-1:0]    r_cfg;
    logic [CFG_W-1:0]    w_mod;
    logic [KEY_W-1:0]    r_port;
    logic [CFG_W-1:0]    r_bucket;
    logic [AW-1:0]       r_base;
    logic [WW-1:0]       r_way;
    logic                w_last_way;
    logic [AW-1:0]       w_rd_addr;

    logic                r_hit;
    logic [AW-1:0]       r_hit_addr;
    logic [CNT_W-1:0]    r_hit_cnt;
    logic                r_free;
    logic [AW-1:0]       r_free_addr;

    logic                r_res_present;
    logic [CNT_W-1:0]    r_res_count;
    logic                r_res_drop;

    logic [KEY_W-1:0]    mem_key [ENTRIES];
    logic [CNT_W-1:0]    mem_cnt [ENTRIES];
    logic [KEY_W-1:0]    r_key_rd;
    logic [CNT_W-1:0]    r_cnt_rd;
    logic [ENTRIES-1:0]  r_valid;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_rem_done;
    logic [CFG_W-1:0]    w_rem;
    logic                w_match;
    logic [CNT_W-1:0]    w_inc_cnt;

    logic                r_out_valid;
    logic [BOUT_W-1:0]   r_out_bucket;
    logic                r_out_present;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_drop;

    // zero acts as one, anything above the table size acts as the table size
    always_comb begin
        w_mod = r_cfg;
        if (r_cfg == '0)
            w_mod = CFG_W'(1);
        else if (32'(r_cfg) > BUCKETS)
            w_mod = CFG_W'(BUCKETS);
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last_way = (r_way == WW'(WAYS - 1));
    assign w_rd_addr  = r_base + AW'(r_way);
    assign w_match    = r_valid[w_rd_addr] && (r_key_rd == r_port);
    assign w_inc_cnt  = (r_hit_cnt == COUNT_MAX) ? r_hit_cnt : r_hit_cnt + COUNT_ONE;

    pact_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_key   (i_port_number),
        .i_mod   (w_mod),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid)
                    n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_rem_done)
                    n_state = ST_READ;
            end
            ST_READ: n_state = ST_CMP;
            ST_CMP: begin
                n_state = w_last_way ? ST_UPD : ST_READ;
            end
            ST_UPD:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_cfg <= CFG_RESET;
        else if (i_cfg_we)
            r_cfg <= i_cfg_data;
    end

    // scan and update datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc)
            r_port <= i_port_number;
        if (r_state == ST_DIV && w_rem_done) begin
            r_bucket <= w_rem;
            r_base   <= AW'(32'(w_rem) * WAYS);
            r_way    <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end
        if (r_state == ST_CMP) begin
            if (w_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_addr <= w_rd_addr;
                r_hit_cnt  <= r_cnt_rd;
            end
            if (!r_valid[w_rd_addr] && !r_free) begin
                r_free      <= 1'b1;
                r_free_addr <= w_rd_addr;
            end
            r_way <= r_way + WW'(1);
        end
        if (r_state == ST_UPD) begin
            r_res_present <= r_hit;
            r_res_drop    <= !r_hit && !r_free;
            if (r_hit)
                r_res_count <= w_inc_cnt;
            else if (r_free)
                r_res_count <= COUNT_ONE;
            else
                r_res_count <= '0;
        end
    end

    // single-port key and count memories
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD && r_hit) begin
            mem_cnt[r_hit_addr] <= w_inc_cnt;
        end else if (r_state == ST_UPD && r_free) begin
            mem_cnt[r_free_addr] <= COUNT_ONE;
            mem_key[r_free_addr] <= r_port;
        end
        r_key_rd <= mem_key[w_rd_addr];
        r_cnt_rd <= mem_cnt[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= '0;
        else if (r_state == ST_UPD && !r_hit && r_free)
            r_valid[r_free_addr] <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (r_state == ST_DONE && w_out_free)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_bucket  <= r_bucket[BOUT_W-1:0];
            r_out_present <= r_res_present;
            r_out_count   <= r_res_count;
            r_out_drop    <= r_res_drop;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bucket_index = r_out_bucket;
    assign o_was_present  = r_out_present;
    assign o_access_count = r_out_count;
    assign o_dropped      = r_out_drop;

endmodule

### hw/rtl/pact_rem.sv
// pact_rem: bit-serial restoring remainder of a 16-bit key by a 5-bit modulus
// one quotient bit per cycle; depends on pact_pkg
module pact_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pact_pkg::KEY_W-1:0]  i_key,
    input  logic [pact_pkg::CFG_W-1:0]  i_mod,
    output logic                        o_done,
    output logic [pact_pkg::CFG_W-1:0]  o_rem
);
    import pact_pkg::*;

    localparam int STEP_W = $clog2(KEY_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [KEY_W-1:0]    r_key;
    logic [CFG_W-1:0]    r_mod;
    logic [CFG_W-1:0]    r_rem;
    logic [CFG_W:0]      w_trial;
    logic                w_ge;
    logic [CFG_W-1:0]    n_rem;

    // shift in the next key bit and subtract the modulus when it fits
    always_comb begin
        w_trial = {r_rem, r_key[KEY_W-1]};
        w_ge    = (w_trial >= {1'b0, r_mod});
        n_rem   = w_ge ? CFG_W'(w_trial - {1'b0, r_mod}) : w_trial[CFG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_mod <= i_mod;
            r_rem <= '0;
        end else if (r_busy) begin
            r_key <= {r_key[KEY_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for port_access_counter_table_top, hit/insert/drop
// predicted in-bench per word; depends on pact_pkg and the block's rtl
module tb_top;
    import pact_pkg::*;

    localparam int BUCKETS    = 16;
    localparam int WAYS       = 4;
    localparam int ENTRIES    = BUCKETS * WAYS;
    localparam int CLK_PERIOD = 10;
    localparam int IDLE_SLACK = 2 * WAYS + 19 + 8;
    localparam int PHASE_WORDS = 458;
    localparam int REHASH_EVERY = 150;

    typedef struct packed {
        logic [BOUT_W-1:0] bucket;
        logic              present;
        logic [CNT_W-1:0]  count;
        logic              drop;
    } t_access_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [KEY_W-1:0]  i_port_number = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [BOUT_W-1:0] o_bucket_index;
    logic              o_was_present;
    logic [CNT_W-1:0]  o_access_count;
    logic              o_dropped;

    // bench copy of the table and of the bucket count register
    logic [KEY_W-1:0]  table_key   [ENTRIES];
    logic              table_valid [ENTRIES];
    logic [CNT_W-1:0]  table_count [ENTRIES];
    logic [CFG_W-1:0]  cfg_buckets = CFG_RESET;

    t_access_result    expected_results[$];
    logic [KEY_W-1:0]  recent_ports[$];
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                errors = 0;
    int                words_sent = 0;
    int                n_hits = 0;
    int                n_inserts = 0;
    int                n_drops = 0;
    int                n_cfg_writes = 0;

    port_access_counter_table_top #(
        .BUCKETS(BUCKETS),
        .WAYS   (WAYS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_port_number (i_port_number),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bucket_index(o_bucket_index),
        .o_was_present (o_was_present),
        .o_access_count(o_access_count),
        .o_dropped     (o_dropped)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // hash, search the ways, then count, insert or drop
    function automatic t_access_result count_access(input logic [KEY_W-1:0] port);
        int unsigned    modulus;
        int unsigned    bkt;
        int             hit_way;
        int             free_way;
        int             e;
        t_access_result res;
        modulus = (cfg_buckets == 0) ? 1 : ((cfg_buckets > BUCKETS) ? BUCKETS : cfg_buckets);
        bkt = port % modulus;
        hit_way = -1;
        free_way = -1;
        for (int w = 0; w < WAYS; w++) begin
            e = bkt * WAYS + w;
            if (table_valid[e]) begin
                if (hit_way < 0 && table_key[e] == port) hit_way = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        res = '0;
        res.bucket = bkt[BOUT_W-1:0];
        if (hit_way >= 0) begin
            e = bkt * WAYS + hit_way;
            if (table_count[e] != COUNT_MAX) table_count[e] = table_count[e] + COUNT_ONE;
            res.present = 1'b1;
            res.count = table_count[e];
            n_hits++;
        end else if (free_way >= 0) begin
            e = bkt * WAYS + free_way;
            table_valid[e] = 1'b1;
            table_key[e] = port;
            table_count[e] = COUNT_ONE;
            res.count = COUNT_ONE;
            n_inserts++;
        end else begin
            res.drop = 1'b1;
            n_drops++;
        end
        return res;
    endfunction

    task automatic send_port(input logic [KEY_W-1:0] port);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_port_number <= port;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.insert(expected_results.size(), count_access(port));
        words_sent++;
    endtask

    // sender holds off until every result is back and the block has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_bucket_count(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_buckets = value;
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [CNT_W-1:0] exp_val,
                                input logic [CNT_W-1:0] act_val);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_access_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual bucket %0d count %0h",
                         $time, o_bucket_index, o_access_count);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_bucket_index !== exp_res.bucket)
                    report_field("bucket_index", CNT_W'(exp_res.bucket), CNT_W'(o_bucket_index));
                if (o_was_present !== exp_res.present)
                    report_field("was_present", CNT_W'(exp_res.present), CNT_W'(o_was_present));
                if (o_access_count !== exp_res.count)
                    report_field("access_count", exp_res.count, o_access_count);
                if (o_dropped !== exp_res.drop)
                    report_field("dropped", CNT_W'(exp_res.drop), CNT_W'(o_dropped));
            end
        end
    end

    // mostly revisits recent ports so hits keep coming once buckets fill
    function automatic logic [KEY_W-1:0] pick_port();
        int               r;
        logic [KEY_W-1:0] port;
        r = $urandom_range(99);
        if (r < 55 && recent_ports.size() != 0)
            port = recent_ports[$urandom_range(recent_ports.size() - 1)];
        else if (r < 80)
            port = KEY_W'($urandom_range(63));
        else
            port = KEY_W'($urandom_range(16'hFFFF));
        recent_ports.insert(recent_ports.size(), port);
        if (recent_ports.size() > 64) void'(recent_ports.pop_front());
        return port;
    endfunction

    // reset bucket count of 11, key extremes and alternating bit patterns
    task automatic test_reset_and_extremes();
        send_port(16'h0000);
        send_port(16'hFFFF);
        send_port(16'h0000);
        send_port(16'hFFFF);
        send_port(16'hAAAA);
        send_port(16'h5555);
    endtask

    // bucket 0 already holds port 0, so the fourth new port there is dropped
    task automatic test_full_bucket();
        send_port(16'd11);
        send_port(16'd22);
        send_port(16'd33);
        send_port(16'd44);
        send_port(16'd11);
    endtask

    task automatic test_bucket_count_edges();
        write_bucket_count(5'd0);
        send_port(16'd7);
        send_port(16'd0);
        write_bucket_count(5'd31);
        send_port(16'd15);
        send_port(16'd31);
        write_bucket_count(5'd17);
        send_port(16'd15);
        write_bucket_count(5'd16);
        send_port(16'd47);
        // rehash moves 65535 to another bucket, then back to where it is stored
        write_bucket_count(5'd13);
        send_port(16'hFFFF);
        write_bucket_count(5'd11);
        send_port(16'hFFFF);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [CFG_W-1:0] start_buckets);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_bucket_count(start_buckets);
        for (int i = 0; i < PHASE_WORDS; i++) begin
            if (i % REHASH_EVERY == REHASH_EVERY - 1)
                write_bucket_count(CFG_W'($urandom_range(31)));
            send_port(pick_port());
        end
    endtask

    initial begin
        for (int e = 0; e < ENTRIES; e++) begin
            table_valid[e] = 1'b0;
            table_key[e]   = '0;
            table_count[e] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_extremes();
        test_full_bucket();
        test_bucket_count_edges();
        test_random_traffic(0, 0, 5'd13);
        test_random_traffic(50, 0, 5'd7);
        test_random_traffic(0, 50, 5'd16);
        test_random_traffic(26, 26, 5'd5);
        write_bucket_count(5'd1);
        for (int i = 0; i < 8; i++) send_port(pick_port());
        wait_idle();

        $display("%0d port words: %0d hits, %0d inserts, %0d drops", words_sent, n_hits,
                 n_inserts, n_drops);
        $display("%0d bucket count writes across four idle/stall mixes", n_cfg_writes);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
